FILE: rtl/msba_pkg.sv
// Shared types and constants of the mean-shift brightness adjust block.
package msba_pkg;

  localparam int unsigned COUNT_BITS_DEF     = 22;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 8;
  localparam int unsigned GAIN_W             = 12;
  localparam int unsigned CHAN_W             = 8;
  localparam int unsigned NUM_LANES          = 3;
  localparam int unsigned DIV_STEP_W         = 3;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 12'd256;
  localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;
  localparam logic KIND_ACCUM  = 1'b0;
  localparam logic KIND_ADJUST = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } res_t;

  typedef struct packed {
    logic acc_en;
    logic acc_clear;
    logic div_start;
    logic div_step;
    logic mul_en;
    logic count_zero;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_OFFSET,
    ST_EMIT,
    ST_ADJUST
  } state_e;

endpackage

FILE: rtl/msba_lane.sv
// One color channel: sum, serial mean divide, offset multiply and pixel adjust.
module msba_lane #(
  parameter int unsigned COUNT_BITS     = msba_pkg::COUNT_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = msba_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msba_pkg::lane_ctrl_t        ctrl_i,
  input  logic [COUNT_BITS:0]         count_i,
  input  logic [msba_pkg::GAIN_W-1:0] gain_i,
  input  logic [msba_pkg::CHAN_W-1:0] acc_pix_i,
  input  logic [msba_pkg::CHAN_W-1:0] adj_pix_i,
  output logic [msba_pkg::CHAN_W-1:0] adj_o
);

  localparam int unsigned CW     = msba_pkg::CHAN_W;
  localparam int unsigned SUM_W  = COUNT_BITS + CW;
  localparam int unsigned CNT_W  = COUNT_BITS + 1;
  localparam int unsigned PROD_W = CW + msba_pkg::GAIN_W;
  localparam int unsigned OFS_W  = PROD_W - GAIN_FRAC_BITS;
  localparam int unsigned ADJ_W  = ((OFS_W > CW + 1) ? OFS_W : CW + 1) + 2;

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CW-1:0]     quo_q, quo_d;
  logic [CW-1:0]     mean_q;
  logic [OFS_W-1:0]  ofs_q;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic [CW-1:0]     mean_sel;
  logic [PROD_W-1:0] prod;
  logic [ADJ_W-1:0]  adj_val;

  // Accumulator; a new frame restarts the sum with the current pixel.
  always_comb begin
    sum_d = ctrl_i.acc_clear ? '0 : sum_q;
    if (ctrl_i.acc_en) begin
      sum_d = sum_d + {{(SUM_W-CW){1'b0}}, acc_pix_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Restoring divide, one quotient bit a cycle. The sum never reaches
  // 256 * count, so the high part starts below the divisor and 8 steps suffice.
  assign shifted = {rem_q, quo_q[CW-1]};
  assign diff    = shifted - {1'b0, count_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (ctrl_i.div_start) begin
      rem_d = {1'b0, sum_q[SUM_W-1:CW]};
      quo_d = sum_q[CW-1:0];
    end else if (ctrl_i.div_step) begin
      if (!diff[CNT_W]) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[CW-2:0], 1'b1};
      end else begin
        rem_d = shifted[CNT_W-1:0];
        quo_d = {quo_q[CW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Mean and scaled offset, taken once per frame.
  assign mean_sel = ctrl_i.count_zero ? '0 : quo_q;
  assign prod     = {{(PROD_W-CW){1'b0}}, mean_sel}
                  * {{(PROD_W-msba_pkg::GAIN_W){1'b0}}, gain_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      mean_q <= mean_sel;
      ofs_q  <= prod[PROD_W-1:GAIN_FRAC_BITS];
    end
  end

  assign adj_val = {{(ADJ_W-CW){1'b0}}, adj_pix_i}
                 - {{(ADJ_W-CW){1'b0}}, mean_q}
                 + {{(ADJ_W-OFS_W){1'b0}}, ofs_q};

  always_comb begin
    if (adj_val[ADJ_W-1]) begin
      adj_o = '0;
    end else if (adj_val > {{(ADJ_W-CW){1'b0}}, msba_pkg::CHAN_MAX}) begin
      adj_o = msba_pkg::CHAN_MAX;
    end else begin
      adj_o = adj_val[CW-1:0];
    end
  end

endmodule

FILE: rtl/msba_merge.sv
// Merge of the lane results into the registered result item and its strobe.
module msba_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        emit_i,
  input  logic [msba_pkg::CHAN_W-1:0] lane_i [msba_pkg::NUM_LANES],
  output logic                        res_valid_o,
  output msba_pkg::res_t              res_o
);

  logic           valid_q;
  msba_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      res_q.out_red   <= lane_i[0];
      res_q.out_green <= lane_i[1];
      res_q.out_blue  <= lane_i[2];
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/mean_shift_brightness_adjust_top.sv
// Top level: frame control, gain register, three channel lanes and result merge.
// Accumulate items (kind 0) and adjust items (kind 1) are taken when not busy; each
// adjust item after a frame's first strobes its result for one cycle on the cycle
// after it is taken. The receiver cannot stall: each result is valid for exactly
// that one cycle. The first adjust item of a frame raises busy while an 8-step
// serial divide per lane forms the channel means and the offset and emit states
// form the scaled offsets and adjust the held pixel. Its result strobes when busy
// drops. The gain is sampled in ST_OFFSET; write it only while the block is idle.
module mean_shift_brightness_adjust_top #(
  parameter int unsigned COUNT_BITS     = msba_pkg::COUNT_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = msba_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  msba_pkg::item_t             item_i,
  output logic                        res_valid_o,
  output msba_pkg::res_t              res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [msba_pkg::GAIN_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = COUNT_BITS + 1;

  msba_pkg::state_e     state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [msba_pkg::DIV_STEP_W-1:0] step_q, step_d;
  logic [msba_pkg::GAIN_W-1:0]     gain_q;
  msba_pkg::item_t      hold_q;
  msba_pkg::item_t      adj_item;
  msba_pkg::lane_ctrl_t ctrl;
  logic                 accept;
  logic                 emit;
  logic [msba_pkg::CHAN_W-1:0] acc_pix [msba_pkg::NUM_LANES];
  logic [msba_pkg::CHAN_W-1:0] adj_pix [msba_pkg::NUM_LANES];
  logic [msba_pkg::CHAN_W-1:0] lane_res [msba_pkg::NUM_LANES];

  assign busy        = (state_q == msba_pkg::ST_DIVIDE) || (state_q == msba_pkg::ST_OFFSET)
                    || (state_q == msba_pkg::ST_EMIT);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= msba_pkg::GAIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      msba_pkg::ST_ACCUM: begin
        if (accept && item_i.kind == msba_pkg::KIND_ADJUST) begin
          state_d = msba_pkg::ST_DIVIDE;
        end
      end
      msba_pkg::ST_DIVIDE: begin
        if (step_q == '1) begin
          state_d = msba_pkg::ST_OFFSET;
        end
      end
      msba_pkg::ST_OFFSET: state_d = msba_pkg::ST_EMIT;
      msba_pkg::ST_EMIT:   state_d = msba_pkg::ST_ADJUST;
      msba_pkg::ST_ADJUST: begin
        if (accept && item_i.kind == msba_pkg::KIND_ACCUM) begin
          state_d = msba_pkg::ST_ACCUM;
        end
      end
      default: state_d = msba_pkg::ST_ACCUM;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    ctrl       = '0;
    emit       = 1'b0;
    adj_item   = item_i;
    count_d    = count_q;
    step_d     = '0;
    ctrl.count_zero = (count_q == '0);
    case (state_q)
      msba_pkg::ST_ACCUM: begin
        if (accept && item_i.kind == msba_pkg::KIND_ACCUM && !count_q[COUNT_BITS]) begin
          ctrl.acc_en = 1'b1;
          count_d     = count_q + CNT_W'(1);
        end
        if (accept && item_i.kind == msba_pkg::KIND_ADJUST) begin
          ctrl.div_start = 1'b1;
        end
      end
      msba_pkg::ST_DIVIDE: begin
        ctrl.div_step = 1'b1;
        step_d        = step_q + msba_pkg::DIV_STEP_W'(1);
      end
      msba_pkg::ST_OFFSET: ctrl.mul_en = 1'b1;
      msba_pkg::ST_EMIT: begin
        adj_item = hold_q;
        emit     = 1'b1;
      end
      msba_pkg::ST_ADJUST: begin
        if (accept && item_i.kind == msba_pkg::KIND_ACCUM) begin
          // New frame: restart the sums with this pixel.
          ctrl.acc_clear = 1'b1;
          ctrl.acc_en    = 1'b1;
          count_d        = CNT_W'(1);
        end
        if (accept && item_i.kind == msba_pkg::KIND_ADJUST) begin
          emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msba_pkg::ST_ACCUM;
      count_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
    end
  end

  // Hold the first adjust pixel while the means are formed.
  always_ff @(posedge clk_i) begin
    if (ctrl.div_start) begin
      hold_q <= item_i;
    end
  end

  assign acc_pix[0] = item_i.red;
  assign acc_pix[1] = item_i.green;
  assign acc_pix[2] = item_i.blue;
  assign adj_pix[0] = adj_item.red;
  assign adj_pix[1] = adj_item.green;
  assign adj_pix[2] = adj_item.blue;

  for (genvar g = 0; g < msba_pkg::NUM_LANES; g++) begin : g_lane
    msba_lane #(
      .COUNT_BITS     (COUNT_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .gain_i    (gain_q),
      .acc_pix_i (acc_pix[g]),
      .adj_pix_i (adj_pix[g]),
      .adj_o     (lane_res[g])
    );
  end

  msba_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .lane_i      (lane_res),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(count_q[COUNT_BITS] && (count_q[COUNT_BITS-1:0] != '0)))
    else $error("pixel count beyond limit");

  a_emit_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msba_pkg::ST_EMIT) |=> res_valid_o)
    else $error("held pixel result not strobed");

  a_accum_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.kind == msba_pkg::KIND_ACCUM) |=> !res_valid_o)
    else $error("accumulate transfer produced a result");

  a_divide_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msba_pkg::ST_DIVIDE && step_q != '1) |=> (state_q == msba_pkg::ST_DIVIDE))
    else $error("divide left early");

endmodule

FILE: tb/sv/mean_shift_brightness_adjust_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the mean-shift brightness adjust block.
module mean_shift_brightness_adjust_top_tb;

  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned MAX_SHOWN       = 10;
  localparam longint unsigned COUNT_LIMIT = 64'd1 << msba_pkg::COUNT_BITS_DEF;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  msba_pkg::item_t             item_i;
  logic                        res_valid_o;
  msba_pkg::res_t              res_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [msba_pkg::GAIN_W-1:0] cfg_data_i;

  mean_shift_brightness_adjust_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Predicted block state
  logic [msba_pkg::GAIN_W-1:0] gain_now;
  longint unsigned   sum_red, sum_green, sum_blue, pixels_summed;
  int unsigned       chan_mean   [msba_pkg::NUM_LANES];
  int unsigned       chan_offset [msba_pkg::NUM_LANES];
  bit                adjusting;

  msba_pkg::res_t adjusted_pixels [$];
  int unsigned mismatch_cnt;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned gain_writes;
  int unsigned frames_sent;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;

  function automatic int unsigned floor_mean(input longint unsigned sum,
                                             input longint unsigned cnt);
    longint unsigned m;
    if (cnt == 0) return 0;
    m = sum / cnt;
    return (m > 255) ? 255 : 32'(m);
  endfunction

  function automatic logic [msba_pkg::CHAN_W-1:0] clamp_chan(input int v);
    if (v > 255) return 8'd255;
    if (v < 0) return 8'd0;
    return v[msba_pkg::CHAN_W-1:0];
  endfunction

  // Advance the predicted state by one pixel; return 1 when it yields a result.
  function automatic bit adjust_pixel(input msba_pkg::item_t px, output msba_pkg::res_t r);
    int unsigned chan [msba_pkg::NUM_LANES];
    logic [msba_pkg::CHAN_W-1:0] outv [msba_pkg::NUM_LANES];
    chan[0] = 32'(px.red);
    chan[1] = 32'(px.green);
    chan[2] = 32'(px.blue);
    r = '0;
    if (px.kind == msba_pkg::KIND_ACCUM) begin
      if (adjusting) begin
        sum_red       = 0;
        sum_green     = 0;
        sum_blue      = 0;
        pixels_summed = 0;
        adjusting     = 1'b0;
      end
      if (pixels_summed < COUNT_LIMIT) begin
        sum_red   += chan[0];
        sum_green += chan[1];
        sum_blue  += chan[2];
        pixels_summed++;
      end
      return 1'b0;
    end
    if (!adjusting) begin
      chan_mean[0] = floor_mean(sum_red, pixels_summed);
      chan_mean[1] = floor_mean(sum_green, pixels_summed);
      chan_mean[2] = floor_mean(sum_blue, pixels_summed);
      for (int c = 0; c < msba_pkg::NUM_LANES; c++)
        chan_offset[c] = (chan_mean[c] * gain_now) >> msba_pkg::GAIN_FRAC_BITS_DEF;
      adjusting = 1'b1;
    end
    for (int c = 0; c < msba_pkg::NUM_LANES; c++)
      outv[c] = clamp_chan(int'(chan[c]) - int'(chan_mean[c]) + int'(chan_offset[c]));
    r.out_red   = outv[0];
    r.out_green = outv[1];
    r.out_blue  = outv[2];
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < MAX_SHOWN) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_chan(input string name, input logic [msba_pkg::CHAN_W-1:0] want,
                            input logic [msba_pkg::CHAN_W-1:0] got);
    if (got !== want)
      note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // Result check: every strobe must match the oldest pending pixel
  always @(posedge clk_i) begin
    msba_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (adjusted_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h", res_o));
      end else begin
        want = adjusted_pixels.pop_front();
        check_chan("out_red", want.out_red, res_o.out_red);
        check_chan("out_green", want.out_green, res_o.out_green);
        check_chan("out_blue", want.out_blue, res_o.out_blue);
      end
    end
  end

  // Watchdog: abort when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic msba_pkg::item_t px_of(input logic kind, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b);
    msba_pkg::item_t px;
    px.kind  = kind;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    return px;
  endfunction

  function automatic msba_pkg::item_t rand_pixel(input logic kind, input int unsigned lo,
                                                 input int unsigned hi);
    return px_of(kind, 8'($urandom_range(hi, lo)), 8'($urandom_range(hi, lo)),
                 8'($urandom_range(hi, lo)));
  endfunction

  function automatic logic [msba_pkg::GAIN_W-1:0] rand_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return msba_pkg::GAIN_RESET;
      default: return msba_pkg::GAIN_W'($urandom_range(4095));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input msba_pkg::item_t px);
    msba_pkg::res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= px;
    do @(posedge clk_i); while (busy);
    if (adjust_pixel(px, r)) adjusted_pixels.push_back(r);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Drop start, drain pending results and let any accumulate work settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (adjusted_pixels.size() != 0 || busy) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_gain(input logic [msba_pkg::GAIN_W-1:0] g);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_now = g;
    gain_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Adjust pass straight out of reset: means are zero, pixels pass unchanged.
  task automatic test_adjust_from_reset();
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd0, 8'd0, 8'd0));
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd255, 8'd255, 8'd255));
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd255, 8'd0, 8'd170));
  endtask

  // Largest gain saturates high, zero gain saturates low.
  task automatic test_gain_extremes();
    write_gain('1);
    send_pixel(px_of(msba_pkg::KIND_ACCUM, 8'd0, 8'd0, 8'd0));
    send_pixel(px_of(msba_pkg::KIND_ACCUM, 8'd255, 8'd255, 8'd255));
    send_pixel(px_of(msba_pkg::KIND_ACCUM, 8'd255, 8'd0, 8'd128));
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd0, 8'd0, 8'd0));
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd255, 8'd255, 8'd255));
    write_gain('0);
    send_pixel(px_of(msba_pkg::KIND_ACCUM, 8'd255, 8'd255, 8'd255));
    send_pixel(px_of(msba_pkg::KIND_ACCUM, 8'd254, 8'd255, 8'd1));
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd0, 8'd0, 8'd0));
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd255, 8'd255, 8'd255));
  endtask

  // Gain written mid adjust pass must wait for the next frame.
  task automatic test_gain_sampling();
    write_gain(12'd512);
    send_pixel(px_of(msba_pkg::KIND_ACCUM, 8'd100, 8'd50, 8'd200));
    send_pixel(px_of(msba_pkg::KIND_ACCUM, 8'd101, 8'd51, 8'd201));
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd10, 8'd20, 8'd30));
    write_gain(12'd128);
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd10, 8'd20, 8'd30));
    send_pixel(px_of(msba_pkg::KIND_ACCUM, 8'd100, 8'd50, 8'd200));
    send_pixel(px_of(msba_pkg::KIND_ADJUST, 8'd10, 8'd20, 8'd30));
    write_gain(msba_pkg::GAIN_RESET);
  endtask

  // Mostly whole frames with random content and gains; some loose items.
  task automatic test_random_frames(input int unsigned idle_pct, input int unsigned n_px);
    int unsigned stop_at, n_acc, n_adj, lo, hi;
    send_idle_pct = idle_pct;
    stop_at = pixels_sent + n_px;
    while (pixels_sent < stop_at) begin
      if ($urandom_range(99) < 30) write_gain(rand_gain());
      lo = $urandom_range(255);
      hi = $urandom_range(255, lo);
      if ($urandom_range(1) == 0) begin
        lo = 0;
        hi = 255;
      end
      if ($urandom_range(99) < 85) begin
        n_acc = $urandom_range(24);
        n_adj = $urandom_range(16, 1);
        frames_sent++;
        repeat (n_acc) send_pixel(rand_pixel(msba_pkg::KIND_ACCUM, lo, hi));
        repeat (n_adj) begin
          if ($urandom_range(99) < 3) write_gain(rand_gain());
          send_pixel(rand_pixel(msba_pkg::KIND_ADJUST, lo, hi));
        end
      end else begin
        repeat ($urandom_range(10, 1)) send_pixel(rand_pixel(1'($urandom_range(1)), 0, 255));
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    item_i        = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    gain_now      = msba_pkg::GAIN_RESET;
    sum_red       = 0;
    sum_green     = 0;
    sum_blue      = 0;
    pixels_summed = 0;
    adjusting     = 1'b0;
    send_idle_pct = 0;
    for (int c = 0; c < msba_pkg::NUM_LANES; c++) begin
      chan_mean[c]   = 0;
      chan_offset[c] = 0;
    end
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_adjust_from_reset();
    test_gain_extremes();
    test_gain_sampling();
    test_random_frames(32, 610);
    test_random_frames(47, 610);
    test_random_frames(0, 610);
    wait_idle();

    $display("Sent %0d pixels in %0d random frames, checked %0d adjusted results",
             pixels_sent, frames_sent, results_seen);
    $display("Gain written %0d times; sender idle at 32%%, 47%% and 0%%; %0d mismatches",
             gain_writes, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/msba_pkg.sv
rtl/msba_lane.sv
rtl/msba_merge.sv
rtl/mean_shift_brightness_adjust_top.sv
tb/sv/mean_shift_brightness_adjust_top_tb.sv
